// ===== rtl/atda_pkg.sv =====
// ----------------------------------------------------------------------------
// atda_pkg
// Shared constants, widths and the arctangent table of the tilt unit.
// ----------------------------------------------------------------------------
package atda_pkg;

    localparam int AVG_COUNT_DEF    = 10;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // CORDIC datapath width (magnitude up to 2^24, numerator up to 2^23, gain 1.65)
    localparam int CW = 28;
    // Angle accumulator width, Q.16 degrees
    localparam int ZW = 26;

    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd21760;

    // Register indexes
    localparam logic [0:0] REG_DEADZONE = 1'b0;
    localparam logic [0:0] REG_AVG_EN   = 1'b1;

    typedef logic signed [CW-1:0] t_cw;
    typedef logic signed [ZW-1:0] t_zw;

    // Word handed from cell to cell
    typedef struct packed {
        logic vld;
        t_cw  x;
        t_cw  y;
        t_zw  z;
    } t_cell_word;

    function automatic t_zw atan_q16(input int idx);
        t_zw r;
        r = '0;
        case (idx)
            0:  r = 26'sd2949120;
            1:  r = 26'sd1740967;
            2:  r = 26'sd919879;
            3:  r = 26'sd466945;
            4:  r = 26'sd234379;
            5:  r = 26'sd117304;
            6:  r = 26'sd58666;
            7:  r = 26'sd29335;
            8:  r = 26'sd14668;
            9:  r = 26'sd7334;
            10: r = 26'sd3667;
            11: r = 26'sd1833;
            12: r = 26'sd917;
            13: r = 26'sd458;
            14: r = 26'sd229;
            15: r = 26'sd115;
            16: r = 26'sd57;
            17: r = 26'sd29;
            18: r = 26'sd14;
            19: r = 26'sd7;
            20: r = 26'sd4;
            21: r = 26'sd2;
            22: r = 26'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/atda_if.sv =====
// ----------------------------------------------------------------------------
// atda_in_if / atda_out_if
// Valid/ready channels carrying a raw sample word and a tilt result word.
// ----------------------------------------------------------------------------
interface atda_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface atda_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] tilt_x;
    logic signed [15:0] tilt_y;
    modport source (output valid, tilt_x, tilt_y, input ready);
    modport sink   (input valid, tilt_x, tilt_y, output ready);
endinterface

// ===== rtl/atda_isqrt.sv =====
// ----------------------------------------------------------------------------
// atda_isqrt
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module atda_isqrt
    import atda_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_val,
    output logic        o_done,
    output logic [23:0] o_root
);

    logic [47:0] r_val, n_val;
    logic [24:0] r_rem, n_rem;
    logic [23:0] r_root, n_root;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [26:0] w_acc;
    logic [26:0] w_trial;

    // remainder never exceeds twice the partial root, so 25 bits hold it
    assign w_acc   = {r_rem, r_val[47:46]};
    assign w_trial = {1'b0, r_root, 2'b01};

    // Restoring step: bring down two bits, try 4*root+1
    always_comb begin
        n_val  = r_val;
        n_rem  = r_rem;
        n_root = r_root;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_val  = i_val;
            n_rem  = '0;
            n_root = '0;
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_val = {r_val[45:0], 2'b00};
            if (w_acc >= w_trial) begin
                n_rem  = 25'(w_acc - w_trial);
                n_root = {r_root[22:0], 1'b1};
            end else begin
                n_rem  = w_acc[24:0];
                n_root = {r_root[22:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/atda_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// atda_cordic_cell
// One CORDIC vectoring micro-rotation with a fixed shift, registered output.
// ----------------------------------------------------------------------------
module atda_cordic_cell
    import atda_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_word i_word,
    output t_cell_word o_word
);

    t_cell_word r_word, n_word;
    t_cw        w_xs, w_ys;

    always_comb begin
        w_xs   = i_word.x >>> STEP;
        w_ys   = i_word.y >>> STEP;
        n_word = i_word;
        if (!i_word.y[CW-1]) begin
            n_word.x = i_word.x + w_ys;
            n_word.y = i_word.y - w_xs;
            n_word.z = i_word.z + atan_q16(STEP);
        end else begin
            n_word.x = i_word.x - w_ys;
            n_word.y = i_word.y + w_xs;
            n_word.z = i_word.z - atan_q16(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else begin
            r_word.vld <= i_word.vld;
        end
        r_word.x <= n_word.x;
        r_word.y <= n_word.y;
        r_word.z <= n_word.z;
    end

    assign o_word = r_word;

endmodule

// ===== rtl/accel_tilt_deadzone_averager_unit.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_deadzone_averager_unit
// Tilt angles from raw accelerometer samples: bit-serial square root, a chain
// of CORDIC cells, clamp, deadzone and optional averaging.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  in_ch     in   valid/ready      accel_x, accel_y, accel_z
//  out_ch    out  valid/ready      tilt_x, tilt_y
//  apb       in   psel/penable     deadzone_deg @0, average_enable @4
//
//  A sample goes from accept to result word through a square root and a
//  pass down the CORDIC cell chain for each axis, then the post step; the
//  word that closes an average also passes through the divide step.
//  One sample at a time; in_ch.ready is high whenever idle, also while a
//  result waits. Reset is synchronous, active low, clears control and the
//  averaging state. If the output register is still full when the next
//  result is ready, the unit holds in its final step until it frees.
// ----------------------------------------------------------------------------
module accel_tilt_deadzone_averager_unit
    import atda_pkg::*;
#(
    parameter int AVG_COUNT    = AVG_COUNT_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atda_in_if.sink     in_ch,
    atda_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NSTEP = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // reciprocal of AVG_COUNT in Q.24, rounded up: exact floor quotient below 2^19
    localparam int          RSH   = 24;
    localparam logic [23:0] RECIP = 24'(((1 << RSH) + AVG_COUNT - 1) / AVG_COUNT);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SQRT  = 3'd1;
    localparam logic [2:0] S_CHAIN = 3'd2;
    localparam logic [2:0] S_POST  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;

    // configuration
    logic [7:0] r_dz;
    logic       r_avg_en;
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_DEADZONE: prdata = {24'd0, r_dz};
            REG_AVG_EN:   prdata = {31'd0, r_avg_en};
            default:      prdata = '0;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz     <= '0;
            r_avg_en <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_DEADZONE: r_dz     <= pwdata[7:0];
                REG_AVG_EN:   r_avg_en <= pwdata[0];
                default:      ;
            endcase
        end
    end

    // sample holding
    logic [2:0]         r_st, n_st;
    logic               r_axis, n_axis;
    logic               r_sq_go, n_sq_go;
    logic signed [15:0] r_ax, r_ay, r_az, n_ax, n_ay, n_az;
    logic               r_zero, n_zero;
    logic signed [15:0] r_tx, r_ty, n_tx, n_ty;
    logic [3:0]         r_cnt, n_cnt;
    logic signed [19:0] r_sx, r_sy, n_sx, n_sy;
    logic               r_ovld, n_ovld;
    logic signed [15:0] r_ox, r_oy, n_ox, n_oy;
    logic [18:0]        r_mx, r_my, n_mx, n_my;
    logic               r_negx, r_negy, n_negx, n_negy;

    // magnitude squares of the two other axes
    logic signed [15:0] w_p, w_q, w_num, w_zc;
    logic [15:0]        w_up, w_uq;
    logic [31:0]        w_sqp, w_sqq;
    logic [31:0]        w_mag2;
    logic               w_sq_start, w_sq_done;
    logic [23:0]        w_root;

    assign w_zc  = r_az[15] ? -16'sd1 : r_az;
    assign w_p   = r_axis ? r_ay : r_ax;
    assign w_num = r_axis ? r_ax : r_ay;
    assign w_q   = w_zc;
    assign w_up  = w_p[15] ? 16'(-w_p) : w_p;
    assign w_uq  = w_q[15] ? 16'(-w_q) : w_q;
    assign w_sqp = 32'(w_up) * 32'(w_up);
    assign w_sqq = 32'(w_uq) * 32'(w_uq);
    assign w_mag2 = w_sqp + w_sqq;

    assign w_sq_start = r_sq_go;

    atda_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   ({w_mag2, 16'd0}),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    // cell chain
    t_cell_word w_chain [0:NSTEP];
    always_comb begin
        w_chain[0].vld = w_sq_done;
        w_chain[0].x   = t_cw'({1'b0, w_root});
        w_chain[0].y   = t_cw'(w_num) <<< 8;
        w_chain[0].z   = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NSTEP; gi++) begin : g_cell
            atda_cordic_cell #(.STEP(gi)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_word  (w_chain[gi]),
                .o_word  (w_chain[gi+1])
            );
        end
    endgenerate

    // post-processing: round, clamp, deadzone (zero input gives zero angle)
    t_zw                w_zr;
    logic signed [17:0] w_v;
    logic signed [17:0] w_d;
    logic signed [15:0] w_ang;
    always_comb begin
        w_zr = (w_chain[NSTEP].z + t_zw'(128)) >>> 8;
        w_v  = r_zero ? 18'sd0 : 18'(w_zr);
        if (w_v > 18'sd21760)       w_v = 18'sd21760;
        else if (w_v < -18'sd21760) w_v = -18'sd21760;
        w_d = $signed({2'b00, r_dz, 8'd0});
        if (w_v < w_d && w_v > -w_d) w_ang = '0;
        else if (w_v > 0)            w_ang = 16'(w_v - w_d);
        else                         w_ang = 16'(w_v + w_d);
    end

    // running sums and their magnitudes
    logic signed [19:0] w_nsx, w_nsy;
    logic [19:0]        w_absx, w_absy;
    assign w_nsx  = r_sx + 20'(r_tx);
    assign w_nsy  = r_sy + 20'(r_ty);
    assign w_absx = w_nsx[19] ? 20'(-w_nsx) : 20'(w_nsx);
    assign w_absy = w_nsy[19] ? 20'(-w_nsy) : 20'(w_nsy);

    // mean by reciprocal multiply, 19 x 24 bit products
    logic [39:0] w_px, w_py;
    logic [15:0] w_qx, w_qy;
    assign w_px = 40'(r_mx) * 40'(RECIP);
    assign w_py = 40'(r_my) * 40'(RECIP);
    assign w_qx = w_px[39:24];
    assign w_qy = w_py[39:24];

    logic w_out_free;
    assign w_out_free = !r_ovld || out_ch.ready;

    assign in_ch.ready   = (r_st == S_IDLE);
    assign out_ch.valid  = r_ovld;
    assign out_ch.tilt_x = r_ox;
    assign out_ch.tilt_y = r_oy;

    // sequencing: two axes, then emit or gather
    always_comb begin
        n_st    = r_st;
        n_axis  = r_axis;
        n_sq_go = 1'b0;
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_az    = r_az;
        n_zero  = r_zero;
        n_tx    = r_tx;
        n_ty    = r_ty;
        n_cnt   = r_cnt;
        n_sx    = r_sx;
        n_sy    = r_sy;
        n_ovld  = r_ovld;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_mx    = r_mx;
        n_my    = r_my;
        n_negx  = r_negx;
        n_negy  = r_negy;
        if (out_ch.valid && out_ch.ready) n_ovld = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (in_ch.valid && in_ch.ready) begin
                    n_ax    = in_ch.accel_x;
                    n_ay    = in_ch.accel_y;
                    n_az    = in_ch.accel_z;
                    n_axis  = 1'b0;
                    n_sq_go = 1'b1;
                    n_st    = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_sq_done) begin
                    n_zero = (w_root == '0) && (w_num == '0);
                    n_st   = S_CHAIN;
                end
            end
            S_CHAIN: begin
                if (w_chain[NSTEP].vld) begin
                    if (!r_axis) begin
                        n_tx    = w_ang;
                        n_axis  = 1'b1;
                        n_sq_go = 1'b1;
                        n_st    = S_SQRT;
                    end else begin
                        n_ty = w_ang;
                        n_st = S_POST;
                    end
                end
            end
            S_POST: begin
                if (!r_avg_en) begin
                    if (w_out_free) begin
                        n_ox   = r_tx;
                        n_oy   = r_ty;
                        n_ovld = 1'b1;
                        n_cnt  = '0;
                        n_sx   = '0;
                        n_sy   = '0;
                        n_st   = S_IDLE;
                    end
                end else if ((5'(r_cnt) + 5'd1) < 5'(AVG_COUNT)) begin
                    n_cnt = r_cnt + 4'd1;
                    n_sx  = w_nsx;
                    n_sy  = w_nsy;
                    n_st  = S_IDLE;
                end else begin
                    n_negx = w_nsx[19];
                    n_negy = w_nsy[19];
                    n_mx   = w_absx[18:0];
                    n_my   = w_absy[18:0];
                    n_cnt  = '0;
                    n_sx   = '0;
                    n_sy   = '0;
                    n_st   = S_DIV;
                end
            end
            S_DIV: begin
                if (w_out_free) begin
                    n_ox   = r_negx ? 16'(-w_qx) : w_qx;
                    n_oy   = r_negy ? 16'(-w_qy) : w_qy;
                    n_ovld = 1'b1;
                    n_st   = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_axis  <= 1'b0;
            r_sq_go <= 1'b0;
            r_cnt   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_axis  <= n_axis;
            r_sq_go <= n_sq_go;
            r_cnt   <= n_cnt;
            r_sx    <= n_sx;
            r_sy    <= n_sy;
            r_ovld  <= n_ovld;
        end
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_az   <= n_az;
        r_zero <= n_zero;
        r_tx   <= n_tx;
        r_ty   <= n_ty;
        r_ox   <= n_ox;
        r_oy   <= n_oy;
        r_mx   <= n_mx;
        r_my   <= n_my;
        r_negx <= n_negx;
        r_negy <= n_negy;
    end

endmodule

// ===== test/accel_tilt_deadzone_averager_unit_tb.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_deadzone_averager_unit_tb
// Drives raw samples through the tilt unit under several deadzone and
// averaging settings, predicts each tilt word with an own CORDIC model and
// compares results in order, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_tilt_deadzone_averager_unit_tb
    import atda_pkg::*;
();

    localparam int N_AVG    = AVG_COUNT_DEF;
    localparam int N_STEPS  = (CORDIC_STEPS_DEF < TABLE_LEN) ? CORDIC_STEPS_DEF : TABLE_LEN;
    localparam int LATENCY  = 2 * (25 + N_STEPS) + 5;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
    } t_tilt;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    atda_in_if  in_ch ();
    atda_out_if out_ch ();

    accel_tilt_deadzone_averager_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and settings
    int     dz_deg;
    bit     avg_on;
    int     n_gathered = 0;
    longint acc_x = 0;
    longint acc_y = 0;

    t_sample sample_q[$];
    t_tilt   tilt_q[$];
    int      send_idle_pct, recv_stall_pct;
    int      hold_len = 0;
    int      hold_seq = 0;
    int      hold_seen = 0;
    int      hold_left = 0;
    bit      failed = 1'b0;
    longint  cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // atan(2^-i) in Q.16 degrees
    function automatic longint atan_step(int i);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    function automatic longint fl_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // one tilt angle: num over the magnitude of p and q, Q8.8 after clamp/deadzone
    function automatic longint tilt_angle_q8(longint num, longint p, longint q);
        longint cx, cy, cz, xs, ys, v, d;
        cx = root_floor(longint'(p * p + q * q) << 16);
        cy = num * 256;
        cz = 0;
        d  = dz_deg * 256;
        if (cx != 0 || cy != 0) begin
            for (int i = 0; i < N_STEPS; i++) begin
                xs = fl_shift(cx, i);
                ys = fl_shift(cy, i);
                if (cy >= 0) begin
                    cx += ys; cy -= xs; cz += atan_step(i);
                end else begin
                    cx -= ys; cy += xs; cz -= atan_step(i);
                end
            end
        end
        v = fl_shift(cz + 128, 8);
        if (v > 21760) v = 21760;
        else if (v < -21760) v = -21760;
        if (v < d && v > -d) v = 0;
        else if (v > 0) v -= d;
        else v += d;
        return v;
    endfunction

    // update averaging state and queue any result word
    task automatic predict_tilt(t_sample s);
        longint x, y, z, tx, ty;
        x = s.ax; y = s.ay; z = s.az;
        if (z < 0) z = -1;
        tx = tilt_angle_q8(y, x, z);
        ty = tilt_angle_q8(x, y, z);
        if (!avg_on) begin
            n_gathered = 0; acc_x = 0; acc_y = 0;
            tilt_q.push_back('{tx: tx[15:0], ty: ty[15:0]});
            return;
        end
        acc_x += tx; acc_y += ty; n_gathered++;
        if (n_gathered < N_AVG) return;
        tx = acc_x / N_AVG;
        ty = acc_y / N_AVG;
        n_gathered = 0; acc_x = 0; acc_y = 0;
        tilt_q.push_back('{tx: tx[15:0], ty: ty[15:0]});
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.accel_x <= '0;
            in_ch.accel_y <= '0;
            in_ch.accel_z <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_tilt('{ax: in_ch.accel_x, ay: in_ch.accel_y, az: in_ch.accel_z});
                void'(sample_q.pop_front());
            end
            if ((!in_ch.valid || in_ch.ready)) begin
                if (in_ch.valid && in_ch.ready && sample_q.size() == 0) begin
                    in_ch.valid <= 1'b0;
                end else if (sample_q.size() > (in_ch.valid && in_ch.ready ? 0 : 0)
                             && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid   <= 1'b1;
                    in_ch.accel_x <= sample_q[0].ax;
                    in_ch.accel_y <= sample_q[0].ay;
                    in_ch.accel_z <= sample_q[0].az;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= hold_len;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_tilt want;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (tilt_q.size() == 0) begin
                    $display("%0t: unexpected word tx=%0d ty=%0d", $time,
                             out_ch.tilt_x, out_ch.tilt_y);
                    failed = 1'b1;
                end else begin
                    want = tilt_q.pop_front();
                    if (out_ch.tilt_x !== want.tx) begin
                        $display("%0t: tilt_x expected %0d actual %0d", $time,
                                 want.tx, out_ch.tilt_x);
                        failed = 1'b1;
                    end
                    if (out_ch.tilt_y !== want.ty) begin
                        $display("%0t: tilt_y expected %0d actual %0d", $time,
                                 want.ty, out_ch.tilt_y);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // timeout
    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(int idx, int val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(idx * 4); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_DEADZONE) dz_deg = val & 8'hff;
        else avg_on = val[0];
    endtask

    function automatic logic signed [15:0] rnd_axis();
        case ($urandom_range(5))
            0:       return 16'(-32768 + $urandom_range(3));
            1:       return 16'(32767 - $urandom_range(3));
            2:       return 16'($urandom_range(32) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
        sample_q.push_back('{ax: x, ay: y, az: z});
    endtask

    // wait for all words and a quiet spell so registers can change
    task automatic drain();
        while (sample_q.size() != 0 || in_ch.valid || tilt_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic random_phase(int n, int idle, int stall);
        send_idle_pct = idle; recv_stall_pct = stall;
        repeat (n) add_sample(rnd_axis(), rnd_axis(), rnd_axis());
        drain();
    endtask

    initial begin
        dz_deg = 0; avg_on = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed: extremes, zero magnitude, negative z, flat and level
        add_sample(0, 0, 0);
        add_sample(100, 0, 0);
        add_sample(-100, 0, 0);
        add_sample(0, 0, 16384);
        add_sample(0, 0, -5);
        add_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
        add_sample(-16'sh8000, -16'sh8000, -16'sh8000);
        add_sample(-16'sh8000, 16'sh7fff, 0);
        add_sample(1, -1, -1);
        add_sample(5000, -3000, 12000);
        add_sample(16'sh5555, 16'shaaaa, 16'sh5555);
        add_sample(16'shaaaa, 16'sh5555, 16'shaaaa);
        drain();

        // deadzone wider than the clamp, then mid-range
        reg_write(REG_DEADZONE, 255);
        add_sample(16'sh7fff, 0, 0);
        add_sample(-300, 8000, 100);
        drain();
        reg_write(REG_DEADZONE, 3);
        add_sample(1000, 60, 16000);
        add_sample(-40, -900, 16000);
        drain();

        // averaging: back-pressure with a long receiver hold-off
        reg_write(REG_AVG_EN, 1);
        hold_len = 600; hold_seq++;
        random_phase(100, 0, 0);
        random_phase(200, 61, 0);

        // toggle averaging mid-count, leaving a partial sum behind
        random_phase(4, 0, 0);
        reg_write(REG_AVG_EN, 0);
        reg_write(REG_DEADZONE, 0);
        hold_len = 300; hold_seq++;
        random_phase(300, 0, 0);
        random_phase(250, 61, 0);
        random_phase(250, 0, 61);
        reg_write(REG_DEADZONE, 255);
        random_phase(50, 15, 15);
        reg_write(REG_DEADZONE, 10);
        reg_write(REG_AVG_EN, 1);
        random_phase(200, 15, 15);
        reg_write(REG_DEADZONE, 0);
        random_phase(300, 0, 61);

        // let any last words arrive
        repeat (LATENCY + 20) @(posedge i_clk);
        if (!failed && tilt_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
